@@ src/assert_macros.svh @@
// Assertion macros used by the RTL of the frame receiver.
// Define SYNTH to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: lbl");
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: lbl");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: lbl");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ src/scfr_pkg.sv @@
// Types and constants of the serial command frame receiver.
// No dependencies.
`timescale 1ns / 1ps

package scfr_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned PARAM_W   = 16;
    localparam int unsigned POS_W     = 4;
    localparam int unsigned STORE_N   = 6;
    localparam int unsigned STORE_IW  = 3;
    localparam int unsigned CFG_IDX_W = 2;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [POS_W-1:0]  t_pos;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_HEADER  = 2'd0,
        CFG_SECOND_HEADER = 2'd1,
        CFG_TAIL          = 2'd2
    } t_cfg_idx;

    localparam t_pos POS_HDR0   = 4'd0;
    localparam t_pos POS_HDR1   = 4'd1;
    localparam t_pos POS_CMD    = 4'd2;
    localparam t_pos POS_SEQ    = 4'd3;
    localparam t_pos POS_P1_LO  = 4'd4;
    localparam t_pos POS_P1_HI  = 4'd5;
    localparam t_pos POS_P2_LO  = 4'd6;
    localparam t_pos POS_P2_HI  = 4'd7;
    localparam t_pos POS_CHKSUM = 4'd8;
    localparam t_pos POS_TAIL   = 4'd9;

    localparam t_byte RST_FIRST_HEADER  = 8'd170;
    localparam t_byte RST_SECOND_HEADER = 8'd85;
    localparam t_byte RST_TAIL          = 8'd13;

endpackage

@@ src/serial_command_frame_receiver_unit.sv @@
// Serial command frame receiver: deframes 10-byte header/XOR/tail frames.
// Depends on scfr_pkg and assert_macros.svh.
//
//   channel  direction  handshake                 payload
//   rx       in         i_rx_valid / o_rx_ready   i_rx_byte
//   cmd      out        o_cmd_valid / i_cmd_ready command, sequence, two params
//   cfg      in         i_cfg_wr_en               i_cfg_addr, i_cfg_wdata
//
// One byte per cycle while the frame step is not stalled; a byte passes the input
// register and then the frame step, which loads the result register on a good tail byte.
// The frame step stalls only while a result waits in the output register;
// the input register then holds one byte and drops ready.
// Reset (synchronous, active low) restores the header/tail values and the hunt.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module serial_command_frame_receiver_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_rx_valid,
    output logic                                   o_rx_ready,
    input  logic [scfr_pkg::BYTE_W-1:0]            i_rx_byte,
    output logic                                   o_cmd_valid,
    input  logic                                   i_cmd_ready,
    output logic [scfr_pkg::BYTE_W-1:0]            o_command_code,
    output logic [scfr_pkg::BYTE_W-1:0]            o_sequence_number,
    output logic signed [scfr_pkg::PARAM_W-1:0]    o_first_param,
    output logic signed [scfr_pkg::PARAM_W-1:0]    o_second_param,
    input  logic                                   i_cfg_wr_en,
    input  logic [scfr_pkg::CFG_IDX_W-1:0]         i_cfg_addr,
    input  logic [scfr_pkg::BYTE_W-1:0]            i_cfg_wdata
);

    scfr_pkg::t_byte r_hdr0, r_hdr1, r_tail;

    logic            r_in_valid;
    scfr_pkg::t_byte r_in_byte;

    scfr_pkg::t_pos  r_pos, n_pos;
    scfr_pkg::t_byte r_xor, n_xor;
    logic            r_chk, n_chk;
    scfr_pkg::t_byte r_store [scfr_pkg::STORE_N];

    logic                                r_out_valid;
    scfr_pkg::t_byte                     r_cmd, r_seq;
    logic signed [scfr_pkg::PARAM_W-1:0] r_p1, r_p2;

    logic                              stage_adv;
    logic                              proc;
    logic                              good;
    logic                              store_we;
    logic [scfr_pkg::STORE_IW-1:0]     store_idx;
    scfr_pkg::t_pos                    pos_off;

    assign stage_adv  = !r_out_valid || i_cmd_ready;
    assign proc       = r_in_valid && stage_adv;
    assign o_rx_ready = !r_in_valid || stage_adv;
    assign pos_off    = r_pos - scfr_pkg::POS_CMD;
    assign store_idx  = pos_off[scfr_pkg::STORE_IW-1:0];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr0 <= scfr_pkg::RST_FIRST_HEADER;
            r_hdr1 <= scfr_pkg::RST_SECOND_HEADER;
            r_tail <= scfr_pkg::RST_TAIL;
        end else if (i_cfg_wr_en) begin
            unique case (scfr_pkg::t_cfg_idx'(i_cfg_addr))
                scfr_pkg::CFG_FIRST_HEADER:  r_hdr0 <= i_cfg_wdata;
                scfr_pkg::CFG_SECOND_HEADER: r_hdr1 <= i_cfg_wdata;
                scfr_pkg::CFG_TAIL:          r_tail <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_rx_ready) begin
            r_in_valid <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx_valid && o_rx_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // frame step
    always_comb begin
        n_pos    = r_pos;
        n_xor    = r_xor;
        n_chk    = r_chk;
        good     = 1'b0;
        store_we = 1'b0;
        if (proc) begin
            unique case (r_pos)
                scfr_pkg::POS_HDR0: begin
                    if (r_in_byte == r_hdr0) begin
                        n_xor = r_in_byte;
                        n_pos = scfr_pkg::POS_HDR1;
                    end
                end
                scfr_pkg::POS_HDR1: begin
                    if (r_in_byte == r_hdr1) begin
                        n_xor = r_xor ^ r_in_byte;
                        n_pos = scfr_pkg::POS_CMD;
                    end else if (r_in_byte == r_hdr0) begin
                        n_xor = r_in_byte;
                        n_chk = 1'b0;
                        n_pos = scfr_pkg::POS_HDR1;
                    end else begin
                        n_xor = '0;
                        n_chk = 1'b0;
                        n_pos = scfr_pkg::POS_HDR0;
                    end
                end
                scfr_pkg::POS_CMD, scfr_pkg::POS_SEQ, scfr_pkg::POS_P1_LO,
                scfr_pkg::POS_P1_HI, scfr_pkg::POS_P2_LO, scfr_pkg::POS_P2_HI: begin
                    store_we = 1'b1;
                    n_xor    = r_xor ^ r_in_byte;
                    n_pos    = r_pos + scfr_pkg::t_pos'(1);
                end
                scfr_pkg::POS_CHKSUM: begin
                    n_chk = (r_in_byte == r_xor);
                    n_pos = scfr_pkg::POS_TAIL;
                end
                scfr_pkg::POS_TAIL: begin
                    good  = r_chk && (r_in_byte == r_tail);
                    n_xor = '0;
                    n_chk = 1'b0;
                    n_pos = scfr_pkg::POS_HDR0;
                end
                default: begin
                    n_chk = 1'b0;
                    if (r_in_byte == r_hdr0) begin
                        n_xor = r_in_byte;
                        n_pos = scfr_pkg::POS_HDR1;
                    end else begin
                        n_xor = '0;
                        n_pos = scfr_pkg::POS_HDR0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= scfr_pkg::POS_HDR0;
            r_xor <= '0;
            r_chk <= 1'b0;
        end else begin
            r_pos <= n_pos;
            r_xor <= n_xor;
            r_chk <= n_chk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[store_idx] <= r_in_byte;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stage_adv) begin
            r_out_valid <= good;
        end
    end

    always_ff @(posedge i_clk) begin
        if (good) begin
            r_cmd <= r_store[0];
            r_seq <= r_store[1];
            r_p1  <= {r_store[3], r_store[2]};
            r_p2  <= {r_store[5], r_store[4]};
        end
    end

    assign o_cmd_valid       = r_out_valid;
    assign o_command_code    = r_cmd;
    assign o_sequence_number = r_seq;
    assign o_first_param     = r_p1;
    assign o_second_param    = r_p2;

    `ASSERT_ALWAYS(a_pos_range, i_clk, i_rst_n, r_pos <= scfr_pkg::POS_TAIL)
    `ASSERT_IMPLY(a_result_from_tail, i_clk, i_rst_n, $rose(r_out_valid), $past(r_pos) == scfr_pkg::POS_TAIL)
    `ASSERT_NEXT(a_tail_restarts, i_clk, i_rst_n, proc && r_pos == scfr_pkg::POS_TAIL, r_pos == scfr_pkg::POS_HDR0 && r_xor == '0)
    `ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !stage_adv, r_in_valid && $stable(r_in_byte))

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for serial_command_frame_receiver_unit.
// Drives serial bytes through valid/ready, predicts decoded command frames
// and compares them field by field; depends on scfr_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_top;
    import scfr_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_TICKS = 8;
    localparam int RANDOM_BYTES = 1300;
    localparam int PHASE_BYTES  = 200;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_CHKSUM,
        FRAME_BAD_TAIL,
        FRAME_TRUNCATED
    } t_frame_kind;

    typedef struct packed {
        t_byte                    cmd;
        t_byte                    seq;
        logic signed [PARAM_W-1:0] p1;
        logic signed [PARAM_W-1:0] p2;
    } t_cmd_frame;

    logic clk;
    logic rst_n     = 1'b0;
    logic rx_valid  = 1'b0;
    t_byte rx_byte  = '0;
    logic cmd_ready = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    t_byte cfg_wdata = '0;

    logic                      rx_ready;
    logic                      cmd_valid;
    t_byte                     cmd_code;
    t_byte                     seq_num;
    logic signed [PARAM_W-1:0] param_a;
    logic signed [PARAM_W-1:0] param_b;

    t_byte hdr0_value = RST_FIRST_HEADER;
    t_byte hdr1_value = RST_SECOND_HEADER;
    t_byte tail_value = RST_TAIL;

    t_pos  rx_pos    = POS_HDR0;
    t_byte rx_xor    = '0;
    t_byte rx_payload [STORE_N];
    bit    rx_chk_ok = 1'b0;

    t_cmd_frame pending_cmds [$];
    bit no_idle     = 1'b0;
    int errors      = 0;
    int bytes_sent  = 0;
    int cycles      = 0;

    serial_command_frame_receiver_unit dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_rx_valid        (rx_valid),
        .o_rx_ready        (rx_ready),
        .i_rx_byte         (rx_byte),
        .o_cmd_valid       (cmd_valid),
        .i_cmd_ready       (cmd_ready),
        .o_command_code    (cmd_code),
        .o_sequence_number (seq_num),
        .o_first_param     (param_a),
        .o_second_param    (param_b),
        .i_cfg_wr_en       (cfg_wr_en),
        .i_cfg_addr        (cfg_addr),
        .i_cfg_wdata       (cfg_wdata)
    );

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            cmd_ready <= 1'b0;
        end else begin
            cmd_ready <= no_idle || ($urandom_range(99) >= 7);
        end
    end

    always @(posedge clk) begin
        t_cmd_frame want;
        if (rst_n && cmd_valid && cmd_ready) begin
            if (pending_cmds.size() == 0) begin
                $error("unexpected command frame: cmd %0d seq %0d p1 %0d p2 %0d",
                       cmd_code, seq_num, param_a, param_b);
                errors++;
            end else begin
                want = pending_cmds.pop_front();
                if (cmd_code !== want.cmd) begin
                    $error("command_code: expected %0d, got %0d", want.cmd, cmd_code);
                    errors++;
                end
                if (seq_num !== want.seq) begin
                    $error("sequence_number: expected %0d, got %0d", want.seq, seq_num);
                    errors++;
                end
                if (param_a !== want.p1) begin
                    $error("first_param: expected %0d, got %0d", want.p1, param_a);
                    errors++;
                end
                if (param_b !== want.p2) begin
                    $error("second_param: expected %0d, got %0d", want.p2, param_b);
                    errors++;
                end
            end
        end
    end

    function automatic void restart_hunt();
        rx_pos    = POS_HDR0;
        rx_xor    = '0;
        rx_chk_ok = 1'b0;
    endfunction

    function automatic void deframe_byte(input t_byte b);
        t_cmd_frame r;
        bit good;
        if (rx_pos > POS_TAIL) restart_hunt();
        case (rx_pos)
            POS_HDR0: begin
                if (b == hdr0_value) begin
                    rx_xor = b;
                    rx_pos = POS_HDR1;
                end
            end
            POS_HDR1: begin
                if (b != hdr1_value) begin
                    restart_hunt();
                    if (b == hdr0_value) begin
                        rx_xor = b;
                        rx_pos = POS_HDR1;
                    end
                end else begin
                    rx_xor = rx_xor ^ b;
                    rx_pos = POS_CMD;
                end
            end
            POS_CHKSUM: begin
                rx_chk_ok = (b == rx_xor);
                rx_pos    = POS_TAIL;
            end
            POS_TAIL: begin
                good = rx_chk_ok && (b == tail_value);
                restart_hunt();
                if (good) begin
                    r.cmd = rx_payload[0];
                    r.seq = rx_payload[1];
                    r.p1  = {rx_payload[3], rx_payload[2]};
                    r.p2  = {rx_payload[5], rx_payload[4]};
                    pending_cmds.push_back(r);
                end
            end
            default: begin
                rx_payload[rx_pos - POS_CMD] = b;
                rx_xor = rx_xor ^ b;
                rx_pos = rx_pos + 1'b1;
            end
        endcase
    endfunction

    task automatic send_byte(input t_byte b);
        while (!no_idle && $urandom_range(99) < 7) begin
            rx_valid <= 1'b0;
            @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!rx_ready) @(posedge clk);
        deframe_byte(b);
        bytes_sent++;
    endtask

    task automatic drain();
        rx_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_byte val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            CFG_FIRST_HEADER:  hdr0_value = val;
            CFG_SECOND_HEADER: hdr1_value = val;
            CFG_TAIL:          tail_value = val;
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input t_byte h0, input t_byte h1, input t_byte tl);
        drain();
        write_reg(CFG_FIRST_HEADER, h0);
        write_reg(CFG_SECOND_HEADER, h1);
        write_reg(CFG_TAIL, tl);
    endtask

    task automatic send_frame(input t_frame_kind kind, input t_byte cmd, input t_byte seq,
                              input logic [PARAM_W-1:0] p1, input logic [PARAM_W-1:0] p2);
        t_byte frame [10];
        int    n;
        frame[0] = hdr0_value;
        frame[1] = hdr1_value;
        frame[2] = cmd;
        frame[3] = seq;
        frame[4] = p1[7:0];
        frame[5] = p1[15:8];
        frame[6] = p2[7:0];
        frame[7] = p2[15:8];
        frame[8] = frame[0] ^ frame[1] ^ frame[2] ^ frame[3]
                 ^ frame[4] ^ frame[5] ^ frame[6] ^ frame[7];
        frame[9] = tail_value;
        n = 10;
        case (kind)
            FRAME_BAD_CHKSUM: frame[8] = frame[8] ^ t_byte'($urandom_range(1, 255));
            FRAME_BAD_TAIL:   frame[9] = frame[9] ^ t_byte'($urandom_range(1, 255));
            FRAME_TRUNCATED:  n = $urandom_range(1, 9);
            default: ;
        endcase
        for (int k = 0; k < n; k++) send_byte(frame[k]);
    endtask

    task automatic send_random_frame(input t_frame_kind kind);
        send_frame(kind, t_byte'($urandom), t_byte'($urandom),
                   PARAM_W'($urandom), PARAM_W'($urandom));
    endtask

    function automatic t_byte pick_reg_value();
        case ($urandom_range(3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return t_byte'($urandom);
        endcase
    endfunction

    task automatic test_reset_values();
        send_frame(FRAME_GOOD, 8'h00, 8'h00, 16'h0000, 16'hFFFF);
        send_frame(FRAME_GOOD, 8'hFF, 8'hFF, 16'h7FFF, 16'h8000);
        send_frame(FRAME_GOOD, 8'h5A, 8'hA5, 16'h8000, 16'h7FFF);
    endtask

    task automatic test_hunting();
        t_byte b;
        for (int k = 0; k < 4; k++) begin
            do b = t_byte'($urandom); while (b == hdr0_value);
            send_byte(b);
        end
        send_random_frame(FRAME_GOOD);
    endtask

    task automatic test_header_resync();
        t_byte b;
        send_byte(hdr0_value);
        send_byte(hdr0_value);
        send_byte(hdr0_value);
        send_random_frame(FRAME_GOOD);
        do b = t_byte'($urandom); while (b == hdr0_value || b == hdr1_value);
        send_byte(hdr0_value);
        send_byte(b);
        send_random_frame(FRAME_GOOD);
    endtask

    task automatic test_bad_frames();
        send_random_frame(FRAME_BAD_CHKSUM);
        send_random_frame(FRAME_BAD_TAIL);
        send_random_frame(FRAME_GOOD);
    endtask

    task automatic test_register_settings();
        configure(8'h00, 8'hFF, 8'h00);
        send_random_frame(FRAME_GOOD);
        configure(8'hFF, 8'h00, 8'hFF);
        send_random_frame(FRAME_GOOD);
        configure(8'h3C, 8'h3C, 8'h3C);
        send_byte(8'h3C);
        send_random_frame(FRAME_GOOD);
        drain();
        write_reg(CFG_UNUSED_IDX, 8'hFF);
        send_random_frame(FRAME_GOOD);
    endtask

    task automatic test_random_traffic();
        int stop_at;
        int next_phase;
        int phase;
        int pick;
        stop_at    = bytes_sent + RANDOM_BYTES;
        next_phase = bytes_sent + PHASE_BYTES;
        phase      = 0;
        while (bytes_sent < stop_at) begin
            if (bytes_sent >= next_phase) begin
                phase++;
                next_phase = bytes_sent + PHASE_BYTES;
                configure(pick_reg_value(), pick_reg_value(), pick_reg_value());
                if ($urandom_range(1) == 0) write_reg(CFG_UNUSED_IDX, t_byte'($urandom));
                no_idle = (phase == 2);
            end
            pick = $urandom_range(99);
            if (pick < 70) begin
                send_random_frame(FRAME_GOOD);
            end else if (pick < 78) begin
                send_random_frame(FRAME_BAD_CHKSUM);
            end else if (pick < 85) begin
                send_random_frame(FRAME_BAD_TAIL);
            end else if (pick < 93) begin
                send_random_frame(FRAME_TRUNCATED);
            end else begin
                repeat ($urandom_range(1, 5)) send_byte(t_byte'($urandom));
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_hunting();
        test_header_resync();
        test_bad_frames();
        test_register_settings();
        test_random_traffic();
        drain();
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
